### hdl/vtpv_pkg.sv
// Shared types and constants for the vertex transform, project and viewport unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package vtpv_pkg;

    // Field and datapath widths
    localparam int COEF_W    = 16;           // Q6.10 matrix coefficient
    localparam int VTX_W     = 16;           // Q8.8 vertex coordinate
    localparam int OPND_W    = VTX_W + 1;    // vertex operand after negation of y
    localparam int PROD_W    = COEF_W + OPND_W;
    localparam int H_W       = PROD_W + 2;   // sum of four products
    localparam int NUM_W     = 64;           // signed numerator of the divide
    localparam int DEN_MAG_W = H_W - 1;      // magnitude of w
    localparam int QUO_W     = 33;           // quotient magnitude bits
    localparam int LANES     = 3;            // x, y, z
    localparam int HALF_W    = 12;
    localparam int DEPTH_W   = 30;
    localparam int ROW_W     = 4 * COEF_W;
    localparam int CFG_IDX_W = 3;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ROW0        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_SCALE = 3'd6;

    // Reset values
    localparam logic [HALF_W-1:0]  HALF_WIDTH_RST  = 12'd320;
    localparam logic [HALF_W-1:0]  HALF_HEIGHT_RST = 12'd240;
    localparam logic [DEPTH_W-1:0] DEPTH_SCALE_RST = 30'd100000000;

    // Lane numbers
    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_Z = 2;

    typedef struct packed {
        logic [3:0][ROW_W-1:0] row;
        logic [HALF_W-1:0]     half_width;
        logic [HALF_W-1:0]     half_height;
        logic [DEPTH_W-1:0]    depth_scale;
    } cfg_t;

    // Per-lane divide result travelling down the divider
    typedef struct packed {
        logic [QUO_W-1:0] quo;
        logic             ovf;
        logic             neg;
        logic             zero;
    } div_res_t;

endpackage

`default_nettype wire

### hdl/vtpv_transform.sv
// Matrix multiply and numerator build: four pipeline stages.
// Depends on vtpv_pkg.
`default_nettype none

module vtpv_transform
    import vtpv_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    advance,
    input  wire logic                    in_valid,
    input  wire logic signed [VTX_W-1:0] vx,
    input  wire logic signed [VTX_W-1:0] vy,
    input  wire logic signed [VTX_W-1:0] vz,
    input  wire cfg_t                    cfg,
    output logic                         out_valid,
    output logic signed [NUM_W-1:0]      num [LANES],
    output logic signed [H_W-1:0]        den
);

    logic                      v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [PROD_W-1:0]  prod_reg [4][4];
    logic signed [PROD_W-1:0]  prod_next [4][4];
    logic signed [OPND_W-1:0]  opnd [4];
    logic signed [H_W-1:0]     h_reg [4];
    logic signed [H_W-1:0]     h_next [4];
    logic signed [48:0]        nx_reg, ny_reg, nx_next, ny_next;
    logic signed [H_W+16-1:0]  zl_reg, zh_reg, zl_next, zh_next;
    logic signed [H_W-1:0]     w3_reg;
    logic signed [NUM_W-1:0]   num_reg [LANES];
    logic signed [NUM_W-1:0]   numz_next;
    logic signed [H_W-1:0]     den_reg;

    // Form operands: y negated, w fixed at one in Q8.8
    always_comb
    begin
        opnd[0] = OPND_W'(vx);
        opnd[1] = -OPND_W'(vy);
        opnd[2] = OPND_W'(vz);
        opnd[3] = OPND_W'(256);
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                prod_next[r][c] = $signed(cfg.row[r][c*COEF_W +: COEF_W]) * opnd[c];
            end
        end
    end

    // Sum each row
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            h_next[r] = H_W'(prod_reg[r][0]) + H_W'(prod_reg[r][1])
                      + H_W'(prod_reg[r][2]) + H_W'(prod_reg[r][3]);
        end
    end

    // Numerators; depth scale split in two halves
    always_comb
    begin
        nx_next = (($signed({h_reg[0][H_W-1], h_reg[0]}) + $signed({h_reg[3][H_W-1], h_reg[3]})))
                  * $signed({1'b0, cfg.half_width});
        ny_next = (($signed({h_reg[1][H_W-1], h_reg[1]}) + $signed({h_reg[3][H_W-1], h_reg[3]})))
                  * $signed({1'b0, cfg.half_height});
        zl_next = h_reg[2] * $signed({1'b0, cfg.depth_scale[14:0]});
        zh_next = h_reg[2] * $signed({1'b0, cfg.depth_scale[29:15]});
        numz_next = NUM_W'(zl_reg) + (NUM_W'(zh_reg) <<< 15);
    end

    // Advance the payload stages
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg   <= prod_next;
            h_reg      <= h_next;
            nx_reg     <= nx_next;
            ny_reg     <= ny_next;
            zl_reg     <= zl_next;
            zh_reg     <= zh_next;
            w3_reg     <= h_reg[3];
            num_reg[LANE_X] <= NUM_W'(nx_reg);
            num_reg[LANE_Y] <= NUM_W'(ny_reg);
            num_reg[LANE_Z] <= numz_next;
            den_reg    <= w3_reg;
        end
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign num       = num_reg;
    assign den       = den_reg;

endmodule

`default_nettype wire

### hdl/vtpv_divider.sv
// Pipelined restoring divider: three numerators over a shared w, one quotient bit a stage.
// Depends on vtpv_pkg.
`default_nettype none

module vtpv_divider
    import vtpv_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   advance,
    input  wire logic                   in_valid,
    input  wire logic signed [NUM_W-1:0] num [LANES],
    input  wire logic signed [H_W-1:0]   den,
    output logic                        out_valid,
    output logic                        out_w_zero,
    output div_res_t                    res [LANES]
);

    localparam int CMP_W = NUM_W + 3;

    logic                 v_reg   [QUO_W+1];
    logic                 wz_reg  [QUO_W+1];
    logic [DEN_MAG_W-1:0] dm_reg  [QUO_W+1];
    logic [NUM_W-1:0]     rem_reg [QUO_W+1][LANES];
    div_res_t             dr_reg  [QUO_W+1][LANES];

    logic [DEN_MAG_W-1:0] dm_next;
    logic [NUM_W-1:0]     rem0_next [LANES];
    div_res_t             dr0_next  [LANES];

    // Take magnitudes, signs and the overflow test
    always_comb
    begin
        dm_next = den[H_W-1] ? DEN_MAG_W'(-den) : DEN_MAG_W'(den);
        for (int l = 0; l < LANES; l++)
        begin
            rem0_next[l]     = num[l][NUM_W-1] ? NUM_W'(-num[l]) : NUM_W'(num[l]);
            dr0_next[l].quo  = '0;
            dr0_next[l].ovf  = {3'b000, rem0_next[l]} >= {dm_next, {QUO_W{1'b0}}};
            dr0_next[l].neg  = num[l][NUM_W-1] ^ den[H_W-1];
            dr0_next[l].zero = (num[l] == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dm_reg[0]  <= dm_next;
            wz_reg[0]  <= (den == '0);
            rem_reg[0] <= rem0_next;
            dr_reg[0]  <= dr0_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (advance)
            v_reg[0] <= in_valid;
    end

    // One quotient bit per stage, most significant first
    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        localparam int B = QUO_W - 1 - k;
        logic [CMP_W-1:0] trial;
        logic [CMP_W-1:0] diff  [LANES];
        logic             ge    [LANES];
        logic [NUM_W-1:0] rem_next [LANES];
        div_res_t         dr_next  [LANES];

        always_comb
        begin
            trial = {{(CMP_W-DEN_MAG_W){1'b0}}, dm_reg[k]} << B;
            for (int l = 0; l < LANES; l++)
            begin
                diff[l]        = {3'b000, rem_reg[k][l]} - trial;
                ge[l]          = {3'b000, rem_reg[k][l]} >= trial;
                rem_next[l]    = ge[l] ? diff[l][NUM_W-1:0] : rem_reg[k][l];
                dr_next[l]     = dr_reg[k][l];
                dr_next[l].quo = {dr_reg[k][l].quo[QUO_W-2:0], ge[l]};
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                dm_reg[k+1]  <= dm_reg[k];
                wz_reg[k+1]  <= wz_reg[k];
                rem_reg[k+1] <= rem_next;
                dr_reg[k+1]  <= dr_next;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else if (advance)
                v_reg[k+1] <= v_reg[k];
        end
    end

    assign out_valid  = v_reg[QUO_W];
    assign out_w_zero = wz_reg[QUO_W];
    assign res        = dr_reg[QUO_W];

endmodule

`default_nettype wire

### hdl/vertex_transform_project_viewport_unit.sv
// Per-vertex transform, perspective divide and viewport mapping: top level.
// Depends on vtpv_pkg, vtpv_transform and vtpv_divider.
`default_nettype none

// The unit takes one vertex per cycle and returns one screen-space transaction per
// vertex, in order, after it passes through four stages of matrix multiply and
// numerator build, one divide set-up stage, 33 divide stages (one quotient bit each)
// and the output register. The whole pipeline stalls as one when the output is
// held, so throughput is one vertex per cycle while the consumer keeps up.
// Configuration writes complete at once and must be made while the unit is idle.
module vertex_transform_project_viewport_unit
    import vtpv_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ROW_W-1:0]        cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic signed [VTX_W-1:0] vertex_x,
    input  wire logic signed [VTX_W-1:0] vertex_y,
    input  wire logic signed [VTX_W-1:0] vertex_z,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic signed [15:0]           screen_x,
    output logic signed [15:0]           screen_y,
    output logic signed [31:0]           screen_z,
    output logic                         w_zero
);

    localparam logic [QUO_W-1:0] HI16 = QUO_W'(32767);
    localparam logic [QUO_W-1:0] HI32 = QUO_W'(2147483647);

    cfg_t                    cfg_reg;
    logic                    advance;
    logic                    tf_valid;
    logic signed [NUM_W-1:0] tf_num [LANES];
    logic signed [H_W-1:0]   tf_den;
    logic                    dv_valid;
    logic                    dv_w_zero;
    div_res_t                dv_res [LANES];
    logic                    out_valid_reg;
    logic signed [15:0]      sx_reg, sy_reg;
    logic signed [31:0]      sz_reg;
    logic                    wz_reg;

    // Round toward zero already done; clamp the signed quotient to its range
    function automatic logic signed [QUO_W-1:0] sat_quot(input div_res_t r,
                                                         input logic [QUO_W-1:0] hi);
        logic big;
        big = r.ovf || (r.quo > hi);
        if (r.zero)
            return '0;
        else if (r.neg)
            return big ? -$signed(hi + QUO_W'(1)) : -$signed(r.quo);
        else
            return big ? $signed(hi) : $signed(r.quo);
    endfunction

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row         <= '0;
            cfg_reg.half_width  <= HALF_WIDTH_RST;
            cfg_reg.half_height <= HALF_HEIGHT_RST;
            cfg_reg.depth_scale <= DEPTH_SCALE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ROW0:        cfg_reg.row[0]      <= cfg_data;
                REG_ROW1:        cfg_reg.row[1]      <= cfg_data;
                REG_ROW2:        cfg_reg.row[2]      <= cfg_data;
                REG_ROW3:        cfg_reg.row[3]      <= cfg_data;
                REG_HALF_WIDTH:  cfg_reg.half_width  <= cfg_data[HALF_W-1:0];
                REG_HALF_HEIGHT: cfg_reg.half_height <= cfg_data[HALF_W-1:0];
                REG_DEPTH_SCALE: cfg_reg.depth_scale <= cfg_data[DEPTH_W-1:0];
                default:         ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // Stall the whole pipeline while a result waits
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    vtpv_transform u_transform (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (in_valid),
        .vx        (vertex_x),
        .vy        (vertex_y),
        .vz        (vertex_z),
        .cfg       (cfg_reg),
        .out_valid (tf_valid),
        .num       (tf_num),
        .den       (tf_den)
    );

    vtpv_divider u_divider (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .in_valid   (tf_valid),
        .num        (tf_num),
        .den        (tf_den),
        .out_valid  (dv_valid),
        .out_w_zero (dv_w_zero),
        .res        (dv_res)
    );

    // Saturate and hold the output transaction
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sx_reg <= 16'(sat_quot(dv_res[LANE_X], HI16));
            sy_reg <= 16'(sat_quot(dv_res[LANE_Y], HI16));
            sz_reg <= 32'(sat_quot(dv_res[LANE_Z], HI32));
            wz_reg <= dv_w_zero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= dv_valid;
    end

    assign out_valid = out_valid_reg;
    assign screen_x  = sx_reg;
    assign screen_y  = sy_reg;
    assign screen_z  = sz_reg;
    assign w_zero    = wz_reg;

endmodule

`default_nettype wire
